// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the encoder speed and turn tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside of reset.
`define ESTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ESTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/estt_pkg.sv -----
// Package with the types and constants of the encoder speed and turn tracker.
package estt_pkg;

    localparam int GAIN_W     = 9;
    localparam int GAIN_FRAC  = 8;
    localparam int SPEED_W    = 22;
    localparam int TOTAL_W    = 48;
    localparam int WARM_W     = 5;
    localparam int ROUND_HALF = 128;

    localparam logic [GAIN_W-1:0] GAIN_ONE   = 9'd256;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd102;

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic signed [TOTAL_W-1:0] t_total;
    typedef logic [GAIN_W-1:0]         t_gain;
    typedef logic [WARM_W-1:0]         t_warm;

    localparam t_speed SPEED_MAX = {1'b0, {(SPEED_W - 1){1'b1}}};
    localparam t_speed SPEED_MIN = {1'b1, {(SPEED_W - 1){1'b0}}};

endpackage

// ----- rtl/encoder_speed_and_turn_tracker_top.sv -----
// Top level of the encoder speed and turn tracker.
// A taken word waits in the input register until the result register is free.
// Throughput: one word per cycle unless the output stalls, set by this register pair.
// The filter multiply-add and the total accumulate both finish in the result cycle.
// Synchronous active-low reset clears angle, speed, warm-up count, total and valids.
// Reset also loads the filter gain with 102.
`include "assert_macros.svh"

module encoder_speed_and_turn_tracker_top
    import estt_pkg::*;
#(
    parameter int ANGLE_BITS      = 14,
    parameter int WARMUP_SAMPLES  = 25,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  t_gain                                   i_cfg_data,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: angle_code.
    input  logic [((ANGLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0: angle_step, filtered_speed, total_angle.
    output logic [((ANGLE_BITS + SPEED_W + TOTAL_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Fields from bit 0: tracking_active.
    output logic                                    m_axis_tuser
);

    localparam int OUT_DATA_W = ((ANGLE_BITS + SPEED_W + TOTAL_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - (ANGLE_BITS + SPEED_W + TOTAL_W);
    localparam t_warm WARM_END = WARM_W'(WARMUP_SAMPLES);

    logic                         r_in_valid;
    logic [ANGLE_BITS-1:0]        r_in_angle;
    logic [ANGLE_BITS-1:0]        r_prev;
    t_speed                       r_speed;
    t_warm                        r_warm;
    t_total                       r_total;
    t_gain                        r_gain;
    logic                         r_out_valid;
    logic signed [ANGLE_BITS-1:0] r_out_step;
    t_speed                       r_out_speed;
    t_total                       r_out_total;
    logic                         r_out_active;

    logic                         out_free;
    logic                         adv;
    logic signed [ANGLE_BITS-1:0] step;
    logic                         active;
    t_speed                       n_speed;
    t_total                       n_total;
    t_warm                        n_warm;

    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign adv           = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_active;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_total, r_out_speed, r_out_step};

    estt_speed_filter #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
    ) u_filter (
        .i_step  (step),
        .i_gain  (r_gain),
        .i_speed (r_speed),
        .o_speed (n_speed)
    );

    always_comb begin
        step   = signed'(r_in_angle - r_prev);
        active = (r_warm >= WARM_END);
        if (active) begin
            n_total = r_total + {{(TOTAL_W - ANGLE_BITS){step[ANGLE_BITS-1]}}, step};
            n_warm  = r_warm;
        end else begin
            n_total = r_total;
            n_warm  = r_warm + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain      <= GAIN_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_speed     <= '0;
            r_warm      <= '0;
            r_total     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain <= i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_prev      <= r_in_angle;
                r_speed     <= n_speed;
                r_warm      <= n_warm;
                r_total     <= n_total;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_angle <= s_axis_tdata[ANGLE_BITS-1:0];
        end
        if (adv) begin
            r_out_step   <= step;
            r_out_speed  <= n_speed;
            r_out_total  <= n_total;
            r_out_active <= active;
        end
    end

    `ESTT_ASSERT(a_warm_bounded, r_warm <= WARM_END, "Warm-up count overran.")
    `ESTT_ASSERT(a_active_warm, r_out_valid && r_out_active |-> r_warm == WARM_END, "Early active.")
    `ESTT_ASSERT(a_speed_copy, adv |=> (r_out_speed == r_speed), "Speed copy lost.")
    `ESTT_ASSERT(a_total_hold, !adv |=> $stable(r_total), "Total moved without a word.")
    `ESTT_ASSERT_ALWAYS(a_ready_full, !s_axis_tready |-> r_in_valid, "Stalled while empty.")

endmodule

// ----- rtl/estt_speed_filter.sv -----
// First-order low-pass speed filter with rounding and saturation.
module estt_speed_filter
    import estt_pkg::*;
#(
    parameter int ANGLE_BITS      = 14,
    parameter int SPEED_FRAC_BITS = 8
) (
    input  logic signed [ANGLE_BITS-1:0] i_step,
    input  t_gain                        i_gain,
    input  t_speed                       i_speed,
    output t_speed                       o_speed
);

    localparam int DQ_W   = ANGLE_BITS + SPEED_FRAC_BITS;
    localparam int PROD_W = ((DQ_W > SPEED_W) ? DQ_W : SPEED_W) + GAIN_W + 1;
    localparam int SUM_W  = PROD_W + 1;

    t_gain                     gain_c;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [GAIN_W:0]    comp_s;
    logic signed [DQ_W-1:0]    step_q;
    logic signed [PROD_W-1:0]  prod_new;
    logic signed [PROD_W-1:0]  prod_old;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   shifted;

    always_comb begin
        gain_c   = (i_gain > GAIN_ONE) ? GAIN_ONE : i_gain;
        gain_s   = signed'({1'b0, gain_c});
        comp_s   = signed'({1'b0, GAIN_ONE - gain_c});
        step_q   = signed'({i_step, {SPEED_FRAC_BITS{1'b0}}});
        prod_new = PROD_W'(step_q) * PROD_W'(gain_s);
        prod_old = PROD_W'(i_speed) * PROD_W'(comp_s);
        sum      = SUM_W'(prod_new) + SUM_W'(prod_old) + SUM_W'(ROUND_HALF);
        shifted  = sum >>> GAIN_FRAC;
        if (shifted > SUM_W'(SPEED_MAX)) begin
            o_speed = SPEED_MAX;
        end else if (shifted < SUM_W'(SPEED_MIN)) begin
            o_speed = SPEED_MIN;
        end else begin
            o_speed = shifted[SPEED_W-1:0];
        end
    end

endmodule
